### hdl/hem_pkg.sv
package hem_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int EXP_W      = 24;
    localparam int NEXP_W     = 3;
    localparam int WEIGHT_W   = 17;
    localparam int NORM_W     = 32;
    localparam int OUT_W      = 32;
    localparam int VSUM_W     = 52;
    localparam int ESUM_W     = 44;
    localparam int NUM_EXP_REGS = 4;

    // Shared divider: DIV_NW-bit dividend, DIV_DW-bit divisor, DIV_QW quotient bits
    localparam int DIV_NW  = 68;
    localparam int DIV_DW  = 44;
    localparam int DIV_QW  = 33;
    localparam int DIV_HI_W = DIV_NW - DIV_QW;
    localparam int DIV_CNT_W = $clog2(DIV_QW);

    // Job queue between front and back
    localparam int JOBQ_DEPTH = 2;
    localparam int JOBQ_PTR_W = 1;
    localparam int JOBQ_CNT_W = 2;

    localparam longint unsigned LN2_Q16 = 64'd45426;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLACK = 3'd0,
        REG_SAT   = 3'd1,
        REG_WHITE = 3'd2,
        REG_NEXP  = 3'd3,
        REG_EXP0  = 3'd4,
        REG_EXP1  = 3'd5,
        REG_EXP2  = 3'd6,
        REG_EXP3  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]                    black_level;
        logic [SAMPLE_W-1:0]                    saturation_level;
        logic [SAMPLE_W-1:0]                    white_point;
        logic [NEXP_W-1:0]                      num_exposures;
        logic [NUM_EXP_REGS-1:0][EXP_W-1:0]     exposure;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic              ovf;
        logic [DIV_QW-1:0] quo;
    } div_rsp_t;

    // Saturate a magnitude with sign to signed Q16.16
    function automatic logic [OUT_W-1:0] sat_mag(input logic neg, input logic ovf,
                                                 input logic [39:0] mag);
        logic [OUT_W-1:0] res;
        if (neg) begin
            if (ovf || mag > 40'h0080000000) res = 32'h8000_0000;
            else                             res = 32'h0 - mag[31:0];
        end else begin
            if (ovf || mag > 40'h007FFFFFFF) res = 32'h7FFF_FFFF;
            else                             res = mag[31:0];
        end
        return res;
    endfunction

    // Unsigned shift-subtract quotient, elaboration only
    function automatic longint unsigned const_udiv(input longint unsigned a,
                                                   input longint unsigned b);
        longint unsigned q, r;
        q = '0;
        r = '0;
        for (int j = 63; j >= 0; j--) begin
            r = (r << 1) | 64'(a[j]);
            if (r >= b) begin
                r    = r - b;
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // Bell weight entry, elaboration only: exp(-(1/x + 1/(1-x) - 4)/10) in Q16
    function automatic logic [WEIGHT_W-1:0] weight_entry(input int rom_bits, input int idx);
        longint unsigned num, u, t, k, r, sum, term, d0, d1;
        num = 64'd1 << (rom_bits + 17);
        d0  = 64'(2 * idx + 1);
        d1  = (64'd2 << rom_bits) - 64'(2 * idx) - 64'd1;
        u   = const_udiv(num, d0) + const_udiv(num, d1);
        t   = (u > 64'd262144) ? const_udiv(u - 64'd262144 + 64'd5, 64'd10) : 64'd0;
        k   = const_udiv(t, LN2_Q16);
        if (k > 64'd40) return '0;
        r    = t - k * LN2_Q16;
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int n = 1; n <= 10; n++) begin
            term = const_udiv(term * r, 64'(n) * 64'd65536);
            if ((n & 1) == 1) sum = sum - term;
            else              sum = sum + term;
        end
        return WEIGHT_W'((sum + (64'd1 << (13 + k))) >> (14 + k));
    endfunction

endpackage

### hdl/hem_div.sv
module hem_div import hem_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 ovf_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DW-1:0]    rem_reg;
    logic [DIV_DW-1:0]    den_reg;
    logic [DIV_QW-1:0]    lo_reg;
    logic [DIV_QW-1:0]    quo_reg;

    logic [DIV_DW:0]      trial;
    logic                 ge;
    logic                 start_ovf;

    // quotient would not fit in DIV_QW bits
    assign start_ovf = {{(DIV_DW-DIV_HI_W){1'b0}}, req.num[DIV_NW-1:DIV_QW]} >= req.den;

    // one restoring step a cycle
    assign trial = {rem_reg, lo_reg[DIV_QW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= !start_ovf;
                done_reg <= start_ovf;
            end else if (busy_reg && cnt_reg == DIV_CNT_W'(DIV_QW - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            ovf_reg <= start_ovf;
            den_reg <= req.den;
            lo_reg  <= req.num[DIV_QW-1:0];
            rem_reg <= DIV_DW'(req.num[DIV_NW-1:DIV_QW]);
            quo_reg <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? DIV_DW'(trial - {1'b0, den_reg}) : trial[DIV_DW-1:0];
            lo_reg  <= {lo_reg[DIV_QW-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_QW-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.quo  = quo_reg;

endmodule

### hdl/hem_front.sv
module hem_front import hem_pkg::*; #(
    parameter int MAX_EXP = 4,
    parameter int CW      = 3,
    parameter int IW      = 2,
    parameter int JOB_W   = 67
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [NEXP_W-1:0]   num_exposures,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,
    output logic                job_push,
    output logic [JOB_W-1:0]    job_data,
    input  logic                job_full
);

    logic [SAMPLE_W-1:0]          store_reg [MAX_EXP];
    logic [IW-1:0]                idx_reg;
    logic [IW-1:0]                idx_next;
    logic [CW-1:0]                n_use;
    logic [CW-1:0]                held;
    logic                         accept;
    logic                         last;
    logic [MAX_EXP*SAMPLE_W-1:0]  samples;

    // exposure count in use, clamped to 1..MAX_EXP
    always_comb begin
        if (num_exposures == '0)                    n_use = CW'(1);
        else if (num_exposures > NEXP_W'(MAX_EXP)) n_use = CW'(MAX_EXP);
        else                                        n_use = CW'(num_exposures);
    end

    assign s_tready = !job_full;
    assign accept   = s_tvalid && s_tready;
    assign held     = CW'(idx_reg) + CW'(1);
    assign last     = held >= n_use;
    assign idx_next = last ? '0 : IW'(held);

    // job carries the held samples with the new one in place
    always_comb begin
        for (int k = 0; k < MAX_EXP; k++) begin
            samples[k*SAMPLE_W +: SAMPLE_W] = (IW'(k) == idx_reg) ? s_tdata : store_reg[k];
        end
    end

    assign job_data = {n_use, samples};
    assign job_push = accept && last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (accept) begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            store_reg[idx_reg] <= s_tdata;
        end
    end

endmodule

### hdl/hem_job_fifo.sv
module hem_job_fifo import hem_pkg::*; #(
    parameter int WIDTH = 67
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0]      mem_reg [JOBQ_DEPTH];
    logic [JOBQ_PTR_W-1:0] wr_reg;
    logic [JOBQ_PTR_W-1:0] rd_reg;
    logic [JOBQ_CNT_W-1:0] cnt_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full    = cnt_reg == JOBQ_CNT_W'(JOBQ_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) wr_reg <= wr_reg + 1'b1;
            if (do_pop)  rd_reg <= rd_reg + 1'b1;
            if (do_push && !do_pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= din;
        end
    end

endmodule

### hdl/hem_back.sv
module hem_back import hem_pkg::*; #(
    parameter int MAX_EXP  = 4,
    parameter int ROM_BITS = 10,
    parameter int CW       = 3,
    parameter int IW       = 2,
    parameter int JOB_W    = 67
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             job_valid,
    input  logic [JOB_W-1:0] job_data,
    output logic             job_pop,
    output div_req_t         div_req,
    input  div_rsp_t         div_rsp,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    localparam int ROM_SIZE = 1 << ROM_BITS;
    localparam logic signed [52:0] PRED_TOP = 53'sd4294901760;

    typedef logic [WEIGHT_W-1:0] rom_t [ROM_SIZE];

    function automatic rom_t build_rom();
        rom_t rom;
        for (int i = 0; i < ROM_SIZE; i++) rom[i] = weight_entry(ROM_BITS, i);
        return rom;
    endfunction

    localparam rom_t WROM = build_rom();

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_NORM   = 10'b00_0000_0010,
        ST_WGT    = 10'b00_0000_0100,
        ST_ACC    = 10'b00_0000_1000,
        ST_RATIO  = 10'b00_0001_0000,
        ST_PMUL   = 10'b00_0010_0000,
        ST_PRND   = 10'b00_0100_0000,
        ST_PSCALE = 10'b00_1000_0000,
        ST_PCHK   = 10'b01_0000_0000,
        ST_DONE   = 10'b10_0000_0000
    } state_t;

    state_t                    state_reg, state_next;
    logic [SAMPLE_W-1:0]       samp_reg [MAX_EXP];
    logic signed [NORM_W-1:0]  norm_reg [MAX_EXP];
    logic [CW-1:0]             n_reg;
    logic [IW-1:0]             i_reg;
    logic                      pass_reg;
    logic                      issued_reg;
    logic                      wzero_reg;
    logic [SAMPLE_W-1:0]       raw_reg;
    logic signed [VSUM_W-1:0]  vsum_reg;
    logic [ESUM_W-1:0]         esum_reg;
    logic signed [NORM_W-1:0]  ref_reg;
    logic signed [56:0]        prod1_reg;
    logic signed [34:0]        p_reg;
    logic signed [51:0]        prod2_reg;
    logic [OUT_W-1:0]          res_reg;
    logic [WEIGHT_W-1:0]       rom_q_reg;
    logic                      m_tvalid_reg;
    logic [OUT_W-1:0]          m_tdata_reg;

    logic                      div_start;
    logic                      last_i;
    logic [SAMPLE_W-1:0]       nd;
    logic [SAMPLE_W-1:0]       sb;
    logic [SAMPLE_W:0]         diff;
    logic [SAMPLE_W:0]         diff_neg;
    logic [SAMPLE_W-1:0]       dmag;
    logic                      wzero_cond;
    logic [SAMPLE_W-1:0]       wnum;
    logic [EXP_W-1:0]          e_i;
    logic [VSUM_W-1:0]         vsum_mag;
    logic                      vneg;
    logic [OUT_W-1:0]          norm_val;
    logic [OUT_W-1:0]          rat_val;
    logic [ROM_BITS-1:0]       rom_addr;
    logic [WEIGHT_W-1:0]       w_use;
    logic signed [49:0]        vprod;
    logic [40:0]               eprod;
    logic [56:0]               p1mag;
    logic [56:0]               rsum;
    logic [40:0]               rnd;
    logic [33:0]               pclamp;
    logic signed [52:0]        pred;
    logic                      in_range;
    logic [32:0]               rsum33;
    logic                      out_free;

    // operands and helpers
    assign last_i   = CW'(i_reg) == (n_reg - CW'(1));
    assign nd       = (cfg.white_point > cfg.black_level) ?
                      (cfg.white_point - cfg.black_level) : SAMPLE_W'(1);
    assign sb       = cfg.saturation_level - cfg.black_level;
    assign diff     = {1'b0, samp_reg[i_reg]} - {1'b0, cfg.black_level};
    assign diff_neg = '0 - diff;
    assign dmag     = diff[SAMPLE_W] ? diff_neg[SAMPLE_W-1:0] : diff[SAMPLE_W-1:0];
    assign wzero_cond = (raw_reg <= cfg.black_level) || (raw_reg >= cfg.saturation_level);
    assign wnum     = raw_reg - cfg.black_level;
    assign e_i      = cfg.exposure[2'(i_reg)];
    assign vneg     = vsum_reg[VSUM_W-1];
    assign vsum_mag = vneg ? VSUM_W'('0 - vsum_reg) : VSUM_W'(vsum_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    // divider results
    assign norm_val = sat_mag(diff[SAMPLE_W], div_rsp.ovf, 40'(div_rsp.quo));
    assign rat_val  = (esum_reg == '0) ?
                      sat_mag(vneg, 1'b0, 40'(vsum_mag >> 16)) :
                      sat_mag(vneg, div_rsp.ovf, 40'(div_rsp.quo));
    assign rom_addr = div_rsp.quo[15 -: ROM_BITS];

    // accumulate products
    assign w_use = wzero_reg ? '0 : rom_q_reg;
    assign vprod = norm_reg[i_reg] * $signed({1'b0, w_use});
    assign eprod = e_i * w_use;

    // prediction rounding and range check
    assign p1mag  = prod1_reg[56] ? 57'('0 - prod1_reg) : 57'(prod1_reg);
    assign rsum   = p1mag + 57'd32768;
    assign rnd    = rsum[56:16];
    assign pclamp = (rnd > 41'h2_0000_0000) ? 34'h2_0000_0000 : rnd[33:0];
    assign pred   = 53'(prod2_reg) + $signed({21'b0, cfg.black_level, 16'b0});
    assign in_range = (pred > 53'sd0) && (pred < PRED_TOP);
    assign rsum33 = {1'b0, pred[31:0]} + 33'd32768;

    // divider operand select
    always_comb begin
        div_req.start = div_start;
        div_req.num   = '0;
        div_req.den   = DIV_DW'(1);
        case (state_reg)
            ST_NORM: begin
                div_req.num = DIV_NW'({dmag, 16'b0});
                div_req.den = DIV_DW'(nd);
            end
            ST_WGT: begin
                div_req.num = DIV_NW'({wnum, 16'b0});
                div_req.den = DIV_DW'(sb);
            end
            ST_RATIO: begin
                div_req.num = {vsum_mag, 16'b0};
                div_req.den = esum_reg;
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        job_pop    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    job_pop    = 1'b1;
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                div_start = !issued_reg;
                if (div_rsp.done) state_next = (n_reg == CW'(1)) ? ST_DONE : ST_WGT;
            end
            ST_WGT: begin
                if (wzero_cond) begin
                    state_next = ST_ACC;
                end else begin
                    div_start = !issued_reg;
                    if (div_rsp.done) state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (last_i)        state_next = ST_RATIO;
                else if (pass_reg) state_next = ST_PMUL;
                else               state_next = ST_NORM;
            end
            ST_RATIO: begin
                if (esum_reg == '0) begin
                    state_next = pass_reg ? ST_DONE : ST_PMUL;
                end else begin
                    div_start = !issued_reg;
                    if (div_rsp.done) state_next = pass_reg ? ST_DONE : ST_PMUL;
                end
            end
            ST_PMUL:   state_next = ST_PRND;
            ST_PRND:   state_next = ST_PSCALE;
            ST_PSCALE: state_next = ST_PCHK;
            ST_PCHK: begin
                if (in_range)    state_next = ST_WGT;
                else if (last_i) state_next = ST_RATIO;
                else             state_next = ST_PMUL;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            issued_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (div_rsp.done)   issued_reg <= 1'b0;
            else if (div_start) issued_reg <= 1'b1;
            if (state_reg == ST_DONE && out_free) m_tvalid_reg <= 1'b1;
            else if (m_tready)                     m_tvalid_reg <= 1'b0;
        end
    end

    // weight table, registered read
    always_ff @(posedge aclk) begin
        rom_q_reg <= WROM[rom_addr];
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    for (int k = 0; k < MAX_EXP; k++)
                        samp_reg[k] <= job_data[k*SAMPLE_W +: SAMPLE_W];
                    n_reg    <= job_data[JOB_W-1 -: CW];
                    i_reg    <= '0;
                    pass_reg <= 1'b0;
                    vsum_reg <= '0;
                    esum_reg <= '0;
                end
            end
            ST_NORM: begin
                raw_reg <= samp_reg[i_reg];
                if (div_rsp.done) begin
                    norm_reg[i_reg] <= norm_val;
                    res_reg         <= norm_val;
                end
            end
            ST_WGT: begin
                wzero_reg <= wzero_cond;
            end
            ST_ACC: begin
                vsum_reg <= vsum_reg + VSUM_W'(vprod);
                esum_reg <= esum_reg + ESUM_W'(eprod);
                i_reg    <= last_i ? '0 : i_reg + 1'b1;
            end
            ST_RATIO: begin
                if (esum_reg == '0 || div_rsp.done) begin
                    if (!pass_reg) begin
                        ref_reg  <= rat_val;
                        pass_reg <= 1'b1;
                        vsum_reg <= '0;
                        esum_reg <= '0;
                    end else begin
                        res_reg <= rat_val;
                    end
                end
            end
            ST_PMUL: begin
                prod1_reg <= ref_reg * $signed({1'b0, e_i});
            end
            ST_PRND: begin
                p_reg <= prod1_reg[56] ? (35'sd0 - $signed({1'b0, pclamp}))
                                       : $signed({1'b0, pclamp});
            end
            ST_PSCALE: begin
                prod2_reg <= p_reg * $signed({1'b0, nd});
            end
            ST_PCHK: begin
                raw_reg <= rsum33[31:16];
                if (!in_range) i_reg <= last_i ? '0 : i_reg + 1'b1;
            end
            ST_DONE: begin
                if (out_free) m_tdata_reg <= res_reg;
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |-> (state_reg == ST_IDLE))
        else $error("job taken while a merge is running");

    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> m_tvalid_reg)
        else $error("finished merge did not load output");

    a_no_div_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> issued_reg)
        else $error("divider result with no request issued");

endmodule

### hdl/hdr_exposure_merge_core.sv
// HDR exposure merge. Raw 16-bit samples of one pixel arrive one request per
// exposure on s_*; once num_exposures samples are held a merge job is queued
// (two pixels deep) and the input keeps taking samples at one a cycle while
// the queue has room. The back end merges one pixel at a time through a
// single shared divider that retires one quotient bit a cycle. A single
// exposure needs only its normalise divide; with n exposures a pixel needs n
// normalise and up to n weight divides in the first pass, a prediction
// multiply, round, scale and range check per exposure and up to n weight
// divides in the second, and up to two ratio divides. Results leave on m_*
// as signed Q16.16 through an output register.
// Configuration is by cfg_we/cfg_index/cfg_data and is only to be changed
// with the block idle.
module hdr_exposure_merge_core import hem_pkg::*; #(
    parameter int MAX_EXPOSURES   = 4,
    parameter int WEIGHT_ROM_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,    // [15:0] pixel_value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,    // [31:0] merged_value
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW    = $clog2(MAX_EXPOSURES + 1);
    localparam int IW    = $clog2(MAX_EXPOSURES);
    localparam int JOB_W = MAX_EXPOSURES * SAMPLE_W + CW;

    cfg_t              cfg_reg;
    logic              job_push;
    logic [JOB_W-1:0]  job_in;
    logic [JOB_W-1:0]  job_out;
    logic              job_pop;
    logic              job_full;
    logic              job_empty;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.black_level      <= '0;
            cfg_reg.saturation_level <= 16'hFFFF;
            cfg_reg.white_point      <= 16'hFFFF;
            cfg_reg.num_exposures    <= NEXP_W'(1);
            for (int k = 0; k < NUM_EXP_REGS; k++) cfg_reg.exposure[k] <= 24'h01_0000;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_BLACK: cfg_reg.black_level      <= cfg_data[SAMPLE_W-1:0];
                REG_SAT:   cfg_reg.saturation_level <= cfg_data[SAMPLE_W-1:0];
                REG_WHITE: cfg_reg.white_point      <= cfg_data[SAMPLE_W-1:0];
                REG_NEXP:  cfg_reg.num_exposures    <= cfg_data[NEXP_W-1:0];
                REG_EXP0:  cfg_reg.exposure[0]      <= cfg_data;
                REG_EXP1:  cfg_reg.exposure[1]      <= cfg_data;
                REG_EXP2:  cfg_reg.exposure[2]      <= cfg_data;
                REG_EXP3:  cfg_reg.exposure[3]      <= cfg_data;
                default: ;
            endcase
        end
    end

    hem_front #(
        .MAX_EXP (MAX_EXPOSURES),
        .CW      (CW),
        .IW      (IW),
        .JOB_W   (JOB_W)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .num_exposures (cfg_reg.num_exposures),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .job_push      (job_push),
        .job_data      (job_in),
        .job_full      (job_full)
    );

    hem_job_fifo #(
        .WIDTH (JOB_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (job_push),
        .din     (job_in),
        .pop     (job_pop),
        .dout    (job_out),
        .full    (job_full),
        .empty   (job_empty)
    );

    hem_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    hem_back #(
        .MAX_EXP  (MAX_EXPOSURES),
        .ROM_BITS (WEIGHT_ROM_BITS),
        .CW       (CW),
        .IW       (IW),
        .JOB_W    (JOB_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job_valid (!job_empty),
        .job_data  (job_out),
        .job_pop   (job_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### tb/sv/hdr_exposure_merge_core_tb.sv
module hdr_exposure_merge_core_tb;
    import hem_pkg::*;

    localparam int ROM_N     = 1024;
    localparam int ROM_SHIFT = 16 - 10;
    localparam int SETTLE    = 800;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    hdr_exposure_merge_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [15:0] pixel_value
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [31:0] merged_value
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the block's settings and held samples
    longint         bell_rom [ROM_N];
    longint         blk_lvl, sat_lvl, white_pt;
    logic [2:0]     exp_count;
    longint         rel_exp [4];
    logic [15:0]    held_px [4];
    int             held_cnt;

    logic [31:0]    merged_expect [$];
    int             err_count;
    bit             tx_idle_en, rx_idle_en;
    int             rx_hold;
    int             rx_gap;

    // exp(-t), t in Q16, result Q16
    function automatic longint bell_exp(longint unsigned t);
        longint unsigned k, r, acc, term;
        k = t / 45426;
        if (k > 40) return 0;
        r    = t - k * 45426;
        acc  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int n = 1; n <= 10; n++) begin
            term = term * r / (64'(n) * 65536);
            if (n % 2 == 1) acc = acc - term;
            else            acc = acc + term;
        end
        return longint'((acc + (64'd1 << (13 + k))) >> (14 + k));
    endfunction

    function automatic void build_bell();
        longint unsigned top, u, t;
        top = 64'd1 << 27;
        for (int i = 0; i < ROM_N; i++) begin
            u = top / (2 * i + 1) + top / (2 * ROM_N - 2 * i - 1);
            t = (u > 262144) ? (u - 262144 + 5) / 10 : 0;
            bell_rom[i] = bell_exp(t);
        end
    endfunction

    function automatic longint clamp_s32(longint v);
        if (v > 64'sd2147483647)  return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint white_span();
        return (white_pt > blk_lvl) ? white_pt - blk_lvl : 1;
    endfunction

    function automatic longint norm_px(longint v);
        return clamp_s32(((v - blk_lvl) * 65536) / white_span());
    endfunction

    function automatic longint bell_weight(longint v);
        longint s;
        if (v <= blk_lvl || v >= sat_lvl) return 0;
        s = ((v - blk_lvl) * 65536) / (sat_lvl - blk_lvl);
        return bell_rom[(s >> ROM_SHIFT) & (ROM_N - 1)];
    endfunction

    function automatic longint unsigned q16_quot(longint unsigned a, longint unsigned b,
                                                 longint unsigned lim);
        longint unsigned q, r, res;
        q = a / b;
        r = a % b;
        if (q > (lim >> 16)) return lim;
        res = (q << 16) + ((r << 16) / b);
        return (res > lim) ? lim : res;
    endfunction

    function automatic longint q16_ratio(longint num, longint unsigned den);
        if (den == 0) return clamp_s32(num / 65536);
        if (num < 0) return -longint'(q16_quot(longint'(-num), den, 64'd2147483648));
        return longint'(q16_quot(num, den, 64'd2147483647));
    endfunction

    function automatic int eff_count();
        if (exp_count == 0) return 1;
        if (exp_count > 4)  return 4;
        return exp_count;
    endfunction

    // Store one sample; queue the merged radiance when the pixel completes
    function automatic void merge_predict(logic [15:0] px);
        int            n;
        longint        vsum, refr, p, mag, pred, w, res;
        longint unsigned esum;
        n = eff_count();
        if (held_cnt >= 4) held_cnt = 0;
        held_px[held_cnt] = px;
        held_cnt++;
        if (held_cnt < n) return;
        held_cnt = 0;
        if (n == 1) begin
            res = norm_px(held_px[0]);
        end else begin
            vsum = 0;
            esum = 0;
            for (int i = 0; i < n; i++) begin
                w = bell_weight(held_px[i]);
                vsum += norm_px(held_px[i]) * w;
                esum += rel_exp[i] * w;
            end
            refr = q16_ratio(vsum, esum);
            vsum = 0;
            esum = 0;
            for (int i = 0; i < n; i++) begin
                p   = refr * rel_exp[i];
                mag = (p < 0) ? -p : p;
                mag = (mag + 32768) >> 16;
                if (mag > (64'sd1 << 33)) mag = 64'sd1 << 33;
                p    = (p < 0) ? -mag : mag;
                pred = p * white_span() + blk_lvl * 65536;
                if (pred <= 0 || pred >= 64'sd65535 * 65536) continue;
                w = bell_weight((pred + 32768) >> 16);
                vsum += norm_px(held_px[i]) * w;
                esum += rel_exp[i] * w;
            end
            res = q16_ratio(vsum, esum);
        end
        merged_expect.insert(merged_expect.size(), 32'(clamp_s32(res)));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %h expected %h at %0t", what, got, want, $time);
        err_count++;
    endtask

    // Result side: check every accepted request, then pick next tready
    initial begin
        logic [31:0] want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (merged_expect.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, 32'h0);
                end else begin
                    want = merged_expect.pop_front();
                    if (m_tdata !== want) report_mismatch("merged_value", m_tdata, want);
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
                rx_gap = $urandom_range(1, 18) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one sample and hold it until taken
    task automatic send_px(input logic [15:0] px);
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        merge_predict(px);
    endtask

    // Sender quiet until all results are back and the back end has settled
    task automatic wait_drained();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (merged_expect.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input longint val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[23:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_BLACK: blk_lvl   = val & 16'hFFFF;
            REG_SAT:   sat_lvl   = val & 16'hFFFF;
            REG_WHITE: white_pt  = val & 16'hFFFF;
            REG_NEXP:  exp_count = val[2:0];
            default:   rel_exp[idx - REG_EXP0] = val & 24'hFFFFFF;
        endcase
    endtask

    task automatic write_all(input longint bl, input longint sl, input longint wp,
                             input int ne, input longint e0, input longint e1,
                             input longint e2, input longint e3);
        write_reg(REG_BLACK, bl);
        write_reg(REG_SAT, sl);
        write_reg(REG_WHITE, wp);
        write_reg(REG_NEXP, ne);
        write_reg(REG_EXP0, e0);
        write_reg(REG_EXP1, e1);
        write_reg(REG_EXP2, e2);
        write_reg(REG_EXP3, e3);
    endtask

    function automatic logic [15:0] pick_px();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6 && sat_lvl > blk_lvl) return 16'($urandom_range(blk_lvl, sat_lvl));
        if (sel < 8) return 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(blk_lvl);
            3: return 16'(sat_lvl);
            4: return 16'(blk_lvl + 1);
            default: return 16'(sat_lvl - 1);
        endcase
    endfunction

    function automatic longint pick_exp();
        case ($urandom_range(0, 15))
            0: return 0;
            1: return 24'hFFFFFF;
            2: return 65536;
            default: return 64'd1 << $urandom_range(13, 19) | $urandom_range(0, 8191);
        endcase
    endfunction

    task automatic random_setup();
        longint bl, sl, wp;
        int ne;
        bl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4096);
        sl = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535)
                                         : $urandom_range(40000, 65535);
        wp = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535)
                                         : $urandom_range(30000, 65535);
        ne = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 4);
        write_all(bl, sl, wp, ne, pick_exp(), pick_exp(), pick_exp(), pick_exp());
    endtask

    // Defaults after reset: single exposure, plain normalisation
    task automatic test_reset_defaults();
        send_px(16'h0000);
        send_px(16'hFFFF);
        send_px(16'h8000);
        send_px(16'h5A5A);
        wait_drained();
    endtask

    task automatic test_directed();
        // four bracketed exposures, extremes of the sample range
        write_all(0, 65535, 65535, 4, 65536, 131072, 262144, 524288);
        send_px(16'h0000); send_px(16'h4000); send_px(16'h8000); send_px(16'hFFFF);
        send_px(16'h1234); send_px(16'h2345); send_px(16'h3456); send_px(16'h4567);
        wait_drained();
        // white point at or below black level: span taken as one
        write_all(1000, 60000, 900, 2, 65536, 131072, 0, 0);
        send_px(16'd500); send_px(16'd20000);
        wait_drained();
        // saturation below black level: all weights zero
        write_all(5000, 4000, 60000, 3, 65536, 98304, 131072, 0);
        send_px(16'd6000); send_px(16'd30000); send_px(16'hFFFF);
        wait_drained();
        // zero exposures, largest exposures
        write_all(256, 65000, 65535, 2, 0, 0, 0, 0);
        send_px(16'd10000); send_px(16'd20000);
        wait_drained();
        write_all(0, 65535, 65535, 4, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_px(16'd100); send_px(16'd200); send_px(16'd300); send_px(16'd400);
        wait_drained();
        // count zero acts as one, count above four acts as four
        write_all(65535, 65535, 65535, 0, 65536, 65536, 65536, 65536);
        send_px(16'hFFFF); send_px(16'h0000);
        wait_drained();
        write_all(64, 65535, 65535, 7, 65536, 32768, 16384, 8192);
        send_px(16'd40000); send_px(16'd30000); send_px(16'd20000); send_px(16'd9000);
        wait_drained();
        // count lowered with three samples held
        write_reg(REG_NEXP, 4);
        send_px(16'd12000); send_px(16'd24000); send_px(16'd36000);
        wait_drained();
        write_reg(REG_NEXP, 2);
        send_px(16'd48000);
        wait_drained();
    endtask

    task automatic test_random(input int items);
        int sent, n, pixels;
        sent = 0;
        while (sent < items) begin
            wait_drained();
            random_setup();
            tx_idle_en = $urandom_range(0, 3) != 0;
            rx_idle_en = $urandom_range(0, 3) != 0;
            n = eff_count();
            pixels = $urandom_range(10, 40);
            for (int p = 0; p < pixels; p++) begin
                // mostly whole pixels, now and then a run of one to four samples
                int len;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : n;
                for (int k = 0; k < len; k++) begin
                    send_px(pick_px());
                    sent++;
                end
            end
        end
        wait_drained();
    endtask

    // Receiver stalls for a long stretch so the job queue fills
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        write_all(100, 65000, 64000, 1, 65536, 65536, 65536, 65536);
        rx_hold = 1500;
        for (int i = 0; i < 40; i++) send_px(pick_px());
        wait_drained();
        write_reg(REG_NEXP, 3);
        rx_hold = 2500;
        for (int i = 0; i < 24; i++) send_px(pick_px());
        wait_drained();
    endtask

    task automatic test_no_idle(input int items);
        wait_drained();
        random_setup();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int i = 0; i < items; i++) send_px(pick_px());
        wait_drained();
    endtask

    initial begin
        err_count  = 0;
        rx_hold    = 0;
        rx_gap     = 0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        build_bell();
        blk_lvl = 0; sat_lvl = 65535; white_pt = 65535; exp_count = 3'd1;
        for (int i = 0; i < 4; i++) begin
            rel_exp[i] = 65536;
            held_px[i] = '0;
        end
        held_cnt = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_directed();
        test_random(1500);
        test_backpressure();
        test_no_idle(300);

        if (err_count == 0 && merged_expect.size() == 0) begin
            $display("hdr_exposure_merge_core_tb: PASS");
        end else begin
            if (merged_expect.size() != 0)
                $display("mismatch: %0d results never arrived", merged_expect.size());
            $display("hdr_exposure_merge_core_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #30000000;
        $display("hdr_exposure_merge_core_tb: FAIL");
        $finish;
    end

endmodule
